FILE: rtl/omtd_pkg.sv
// Shared types and constants for the owned mutex table with data.
// Field widths, operation codes and result codes; no dependencies.
`timescale 1ns / 1ps

package omtd_pkg;

   // Fixed widths of the request and response fields
   localparam int MODE_W  = 2;
   localparam int SLOT_W  = 5;
   localparam int ID_W    = 5;
   localparam int WDATA_W = 32;
   localparam int RDATA_W = 32;
   localparam int CODE_W  = 3;

   // Slots that a SLOT_W-bit index can reach
   localparam int SLOT_REACH = 1 << SLOT_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ    = 2'd0,
      MODE_WRITE   = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   typedef enum logic [CODE_W-1:0] {
      RC_NONE              = 3'd0,
      RC_READ_OK           = 3'd1,
      RC_READ_LOCKED       = 3'd2,
      RC_WRITE_OK          = 3'd3,
      RC_WRITE_NOT_OWNER   = 3'd4,
      RC_RELEASE_OK        = 3'd5,
      RC_RELEASE_UNLOCKED  = 3'd6,
      RC_RELEASE_NOT_OWNER = 3'd7
   } result_code_type;

endpackage

FILE: rtl/owned_mutex_table_with_data.sv
// Top level of the owned mutex table with data: slot table, request register,
// response register and assertions. Depends on omtd_pkg.
`timescale 1ns / 1ps

// A table of lockable slots, each with a locked flag, an owner id and a data
// word, all cleared by reset. A transaction is accepted on a rising edge with
// start high and busy low; busy is never raised, so one transaction can be
// accepted every cycle. Each transaction yields exactly one response, shown on
// the rsp_ ports for a single cycle with rsp_strobe high, once it has passed
// the request register and then the slot read-modify-write feeding the
// response register. The receiver cannot stall: sample the response in the
// cycle rsp_strobe is high. The table is updated at the same edge that loads
// the response, so back-to-back transactions on the same slot see each other
// in order. Read locks an unlocked slot and returns its data; write locks an
// unlocked slot or updates a slot the requester owns; release unlocks only
// for the owner and keeps the data word. A slot index of SLOTS or more, or the
// no-operation mode, changes nothing and returns code none. rsp_read_data is
// zero unless the code is read ok. Only the first 32 slots are reachable by
// the 5-bit index, so storage is sized to the smaller of SLOTS and 32.
module owned_mutex_table_with_data #(
   parameter int SLOTS      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [omtd_pkg::MODE_W-1:0]      req_mode,
   input  logic [omtd_pkg::SLOT_W-1:0]      req_slot_index,
   input  logic [omtd_pkg::ID_W-1:0]        req_requester_id,
   input  logic [omtd_pkg::WDATA_W-1:0]     req_write_data,
   output logic                             rsp_strobe,
   output logic [omtd_pkg::CODE_W-1:0]      rsp_result_code,
   output logic [omtd_pkg::RDATA_W-1:0]     rsp_read_data
);

   // Storage depth: slots beyond the index reach can never be addressed
   localparam int DEPTH = (SLOTS < omtd_pkg::SLOT_REACH) ? SLOTS : omtd_pkg::SLOT_REACH;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Request register
   logic                          req_valid_ff;
   logic [omtd_pkg::MODE_W-1:0]   req_mode_ff;
   logic [omtd_pkg::SLOT_W-1:0]   req_slot_ff;
   logic [omtd_pkg::ID_W-1:0]     req_id_ff;
   logic [omtd_pkg::WDATA_W-1:0]  req_wdata_ff;

   // Slot table
   logic                          lock_flags_ff [DEPTH];
   logic [omtd_pkg::ID_W-1:0]     owner_ids_ff  [DEPTH];
   logic [DATA_WIDTH-1:0]         slot_words_ff [DEPTH];

   // Response register
   logic                          rsp_strobe_ff;
   omtd_pkg::result_code_type     rsp_code_ff;
   logic [omtd_pkg::RDATA_W-1:0]  rsp_data_ff;

   // Read-modify-write of the addressed slot
   logic                          accept;
   logic                          in_range;
   logic [IDX_W-1:0]              cur_idx;
   logic                          cur_locked;
   logic                          cur_owns;
   logic [DATA_WIDTH+omtd_pkg::RDATA_W-1:0]  word_ext;
   logic [DATA_WIDTH+omtd_pkg::WDATA_W-1:0]  wdata_ext;
   logic                          slot_we;
   logic                          lock_in;
   logic [omtd_pkg::ID_W-1:0]     owner_in;
   logic                          word_we;
   logic [DATA_WIDTH-1:0]         word_in;
   omtd_pkg::result_code_type     rsp_code_in;
   logic [omtd_pkg::RDATA_W-1:0]  rsp_data_in;

   // One transaction per cycle; never hold off the sender
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign in_range   = (int'(req_slot_ff) < SLOTS);
   assign cur_idx    = req_slot_ff[IDX_W-1:0];
   assign cur_locked = lock_flags_ff[cur_idx];
   assign cur_owns   = cur_locked && (owner_ids_ff[cur_idx] == req_id_ff);

   // Zero-extend before slicing so any DATA_WIDTH maps both ways
   assign word_ext  = {{omtd_pkg::RDATA_W{1'b0}}, slot_words_ff[cur_idx]};
   assign wdata_ext = {{DATA_WIDTH{1'b0}}, req_wdata_ff};
   assign word_in   = wdata_ext[DATA_WIDTH-1:0];

   always_comb begin
      slot_we     = 1'b0;
      lock_in     = cur_locked;
      owner_in    = owner_ids_ff[cur_idx];
      word_we     = 1'b0;
      rsp_code_in = omtd_pkg::RC_NONE;
      rsp_data_in = '0;
      if (req_valid_ff && in_range) begin
         unique case (omtd_pkg::mode_type'(req_mode_ff))
            omtd_pkg::MODE_READ: begin
               if (cur_locked) begin
                  rsp_code_in = omtd_pkg::RC_READ_LOCKED;
               end else begin
                  slot_we     = 1'b1;
                  lock_in     = 1'b1;
                  owner_in    = req_id_ff;
                  rsp_data_in = word_ext[omtd_pkg::RDATA_W-1:0];
                  rsp_code_in = omtd_pkg::RC_READ_OK;
               end
            end
            omtd_pkg::MODE_WRITE: begin
               if (!cur_locked || cur_owns) begin
                  slot_we     = 1'b1;
                  lock_in     = 1'b1;
                  owner_in    = req_id_ff;
                  word_we     = 1'b1;
                  rsp_code_in = omtd_pkg::RC_WRITE_OK;
               end else begin
                  rsp_code_in = omtd_pkg::RC_WRITE_NOT_OWNER;
               end
            end
            omtd_pkg::MODE_RELEASE: begin
               priority if (!cur_locked) begin
                  rsp_code_in = omtd_pkg::RC_RELEASE_UNLOCKED;
               end else if (cur_owns) begin
                  // Drop the lock and owner; keep the data word
                  slot_we     = 1'b1;
                  lock_in     = 1'b0;
                  owner_in    = '0;
                  rsp_code_in = omtd_pkg::RC_RELEASE_OK;
               end else begin
                  rsp_code_in = omtd_pkg::RC_RELEASE_NOT_OWNER;
               end
            end
            omtd_pkg::MODE_NOP: begin
               rsp_code_in = omtd_pkg::RC_NONE;
            end
            default: begin
               rsp_code_in = omtd_pkg::RC_NONE;
            end
         endcase
      end
   end

   // Request register: capture the transaction, no reset on payload
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
      if (accept) begin
         req_mode_ff  <= req_mode;
         req_slot_ff  <= req_slot_index;
         req_id_ff    <= req_requester_id;
         req_wdata_ff <= req_write_data;
      end
   end

   // Slot table: clear everything at reset, else commit the addressed slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            lock_flags_ff[i] <= 1'b0;
            owner_ids_ff[i]  <= '0;
            slot_words_ff[i] <= '0;
         end
      end else begin
         if (slot_we) begin
            lock_flags_ff[cur_idx] <= lock_in;
            owner_ids_ff[cur_idx]  <= owner_in;
         end
         if (word_we) begin
            slot_words_ff[cur_idx] <= word_in;
         end
      end
   end

   // Response register: strobe for exactly one cycle per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
      rsp_code_ff <= rsp_code_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_read_data   = rsp_data_ff;

   // Every response traces back to an accepted transaction through the request and response registers
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("response without an accepted transaction");

   // Every accepted transaction produces a response through the request and response registers
   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted transaction lost");

   // Read data stays zero unless the read succeeded
   a_rdata_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_result_code != omtd_pkg::RC_READ_OK)) |-> (rsp_read_data == '0))
      else $error("read data on a non-read-ok response");

   // A successful read or write leaves the slot locked
   a_lock_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_result_code == omtd_pkg::RC_READ_OK ||
                      rsp_result_code == omtd_pkg::RC_WRITE_OK))
      |-> lock_flags_ff[$past(cur_idx)])
      else $error("slot not locked after a successful lock");

endmodule
